[sv/eitp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EIT section parser package
// Shared types, field widths, protocol codes and a helper function.
// ----------------------------------------------------------------------------
package eitp_pkg;

  // Field widths.
  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 12;
  localparam int unsigned IdentW   = 16;
  localparam int unsigned StartW   = 40;
  localparam int unsigned DurW     = 19;
  localparam int unsigned DurAccW  = 20;
  localparam int unsigned LoopW    = 13;
  localparam int unsigned CountW   = 4;
  localparam int unsigned CfgIdxW  = 1;

  // Stream data widths, padded to whole bytes.
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 104;
  localparam int unsigned OutUsedW = 2 * IdentW + StartW + DurW + ByteW;

  // Accepted table id range and minimum lengths.
  localparam logic [ByteW-1:0]  TidLow       = 8'h4e;
  localparam logic [ByteW-1:0]  TidHigh      = 8'h6f;
  localparam logic [LenW-1:0]   MinBodyLen   = 12'd11;
  localparam logic [CountW-1:0] HeaderBytes  = 4'd11;
  localparam logic [LenW-1:0]   EventHdrLen  = 12'd12;
  localparam logic [DurAccW-1:0] DurSatMax   = 20'h7ffff;

  // Byte positions inside the event header.
  localparam logic [CountW-1:0] EvIdHi     = 4'd0;
  localparam logic [CountW-1:0] EvIdLo     = 4'd1;
  localparam logic [CountW-1:0] EvStart0   = 4'd2;
  localparam logic [CountW-1:0] EvStartEnd = 4'd6;
  localparam logic [CountW-1:0] EvHours    = 4'd7;
  localparam logic [CountW-1:0] EvMinutes  = 4'd8;
  localparam logic [CountW-1:0] EvSeconds  = 4'd9;
  localparam logic [CountW-1:0] EvLoopHi   = 4'd10;

  // Short event descriptor walk positions.
  localparam logic [CountW-1:0] SeTlen  = 4'd3;
  localparam logic [CountW-1:0] SeTitle = 4'd4;
  localparam logic [CountW-1:0] SeDlen  = 4'd5;
  localparam logic [CountW-1:0] SeDesc  = 4'd6;
  localparam logic [CountW-1:0] SeOk    = 4'd7;
  localparam logic [CountW-1:0] SeBad   = 4'd8;

  // Content descriptor: position of the first body byte.
  localparam logic [CountW-1:0] CtFirst = 4'd1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegShortEventTag = 1'b0;
  localparam logic [CfgIdxW-1:0] RegContentTag    = 1'b1;

  localparam logic [ByteW-1:0] ShortEventTagRst = 8'd77;
  localparam logic [ByteW-1:0] ContentTagRst    = 8'd84;

  typedef enum logic [5:0] {
    PhIdle   = 6'b000001,
    PhHeader = 6'b000010,
    PhEvent  = 6'b000100,
    PhDtag   = 6'b001000,
    PhDlen   = 6'b010000,
    PhDbody  = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] short_event_tag;
    logic [ByteW-1:0] content_tag;
  } cfg_t;

  typedef struct packed {
    logic [LenW-1:0]  body_length;
    logic [ByteW-1:0] table_ident;
    logic             section_start;
    logic [ByteW-1:0] section_byte;
  } in_item_t;

  typedef struct packed {
    logic             content_present;
    logic [ByteW-1:0] content_byte;
    logic [DurW-1:0]  duration_seconds;
    logic [StartW-1:0] start_raw;
    logic [IdentW-1:0] event_ident;
    logic [IdentW-1:0] service_ident;
  } result_t;

  // Two BCD digits read as a decimal number (non-decimal nibbles used as is).
  function automatic logic [ByteW-1:0] bcd_value(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] hi;
    logic [ByteW-1:0] lo;
    hi = {4'b0, b[7:4]};
    lo = {4'b0, b[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

endpackage

[sv/eitp_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EIT section parser core
// Byte-wide state machine that walks the section header, event headers and
// descriptor loops, and flags a finished event in the cycle of its last byte.
// ----------------------------------------------------------------------------
module eitp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  eitp_pkg::in_item_t in_item_i,
  input  eitp_pkg::cfg_t    cfg_i,
  output logic              emit_o,
  output eitp_pkg::result_t result_o
);
  import eitp_pkg::*;

  phase_e              phase_q, phase_d, ph;
  logic [CountW-1:0]   bc_q, bc_d, k;
  logic [LenW-1:0]     rem_q, rem_d, rem_in;
  logic signed [LoopW-1:0] loop_q, loop_d;
  logic [ByteW-1:0]    desc_q, desc_d, dr;
  logic [ByteW-1:0]    tag_q, tag_d;
  logic [ByteW-1:0]    str_q, str_d, sr;
  logic [IdentW-1:0]   svc_q, svc_d;
  logic [IdentW-1:0]   ev_q, ev_d;
  logic [StartW-1:0]   start_q, start_d;
  logic [DurAccW-1:0]  dur_q, dur_d, dur_sum;
  logic [ByteW:0]      cont_q, cont_d;
  logic [LoopW-1:0]    loop_set;
  logic [ByteW-1:0]    b, bcd_b;
  logic                act, do_end, do_fin, do_next, emit, reject, is_se, is_ct;

  assign b      = in_item_i.section_byte;
  assign bcd_b  = bcd_value(b);
  assign is_se  = (tag_q == cfg_i.short_event_tag);
  assign is_ct  = (tag_q == cfg_i.content_tag);
  assign reject = (in_item_i.table_ident < TidLow) || (in_item_i.table_ident > TidHigh) ||
                  (in_item_i.body_length < MinBodyLen);
  assign dur_sum  = dur_q + DurAccW'(bcd_b);
  assign loop_set = {1'b0, loop_q[11:8], b};

  always_comb begin
    phase_d = phase_q;
    bc_d    = bc_q;
    rem_d   = rem_q;
    loop_d  = loop_q;
    desc_d  = desc_q;
    tag_d   = tag_q;
    str_d   = str_q;
    svc_d   = svc_q;
    ev_d    = ev_q;
    start_d = start_q;
    dur_d   = dur_q;
    cont_d  = cont_q;
    ph      = phase_q;
    rem_in  = rem_q;
    k       = bc_q;
    dr      = desc_q;
    sr      = str_q;
    act     = 1'b0;
    do_end  = 1'b0;
    do_fin  = 1'b0;
    do_next = 1'b0;
    emit    = 1'b0;

    if (in_valid_i) begin
      if (in_item_i.section_start) begin
        k    = '0;
        bc_d = '0;
        if (reject) begin
          ph     = PhIdle;
          rem_in = '0;
        end else begin
          ph     = PhHeader;
          rem_in = in_item_i.body_length;
        end
      end
      phase_d = ph;
      rem_d   = rem_in;
      if (ph != PhIdle) begin
        if (rem_in == '0) begin
          phase_d = PhIdle;
        end else begin
          rem_d = rem_in - 1'b1;
          act   = 1'b1;
        end
      end
    end

    if (act) begin
      unique case (ph)
        PhHeader: begin
          if (k == EvIdHi) begin
            svc_d = {b, 8'h00};
          end else if (k == EvIdLo) begin
            svc_d = {svc_q[15:8], svc_q[7:0] | b};
          end
          bc_d = k + 1'b1;
          if (bc_d >= HeaderBytes) begin
            do_next = 1'b1;
          end
        end
        PhEvent: begin
          bc_d = k + 1'b1;
          priority if (k == EvIdHi) begin
            ev_d   = {b, 8'h00};
            cont_d = '0;
          end else if (k == EvIdLo) begin
            ev_d = {ev_q[15:8], ev_q[7:0] | b};
          end else if (k == EvStart0) begin
            start_d = {32'b0, b};
          end else if (k <= EvStartEnd) begin
            start_d = {start_q[31:0], b};
          end else if (k == EvHours) begin
            dur_d = DurAccW'(bcd_b) * DurAccW'(3600);
          end else if (k == EvMinutes) begin
            dur_d = dur_q + DurAccW'(bcd_b) * DurAccW'(60);
          end else if (k == EvSeconds) begin
            dur_d = (dur_sum > DurSatMax) ? DurSatMax : dur_sum;
          end else if (k == EvLoopHi) begin
            loop_d = {1'b0, b[3:0], 8'h00};
          end else begin
            loop_d = signed'(loop_set);
            bc_d   = '0;
            if (loop_set > {1'b0, rem_d}) begin
              phase_d = PhIdle;
            end else if (loop_set == '0) begin
              do_fin = 1'b1;
            end else begin
              phase_d = PhDtag;
            end
          end
        end
        PhDtag: begin
          tag_d  = b;
          loop_d = loop_q - 1'b1;
          if (rem_d == '0) begin
            do_fin = 1'b1;
          end else begin
            phase_d = PhDlen;
          end
        end
        PhDlen: begin
          loop_d = loop_q - 1'b1;
          if ({4'b0, b} > rem_d) begin
            do_fin = 1'b1;
          end else begin
            desc_d = b;
            bc_d   = (!is_se && is_ct && b >= 8'd2) ? CtFirst : '0;
            if (b == '0) begin
              do_end = 1'b1;
            end else begin
              phase_d = PhDbody;
            end
          end
        end
        PhDbody: begin
          if (desc_q != '0) begin
            dr = desc_q - 1'b1;
          end
          desc_d = dr;
          loop_d = loop_q - 1'b1;
          if (is_se) begin
            if (k < SeTlen) begin
              bc_d = k + 1'b1;
            end else if (k == SeTlen || k == SeDlen) begin
              if (b > dr) begin
                bc_d = SeBad;
              end else begin
                str_d = b;
                if (k == SeTlen) begin
                  bc_d = (b != '0) ? SeTitle : SeDlen;
                end else begin
                  bc_d = (b != '0) ? SeDesc : SeOk;
                end
              end
            end else if (k == SeTitle || k == SeDesc) begin
              if (str_q != '0) begin
                sr = str_q - 1'b1;
              end
              str_d = sr;
              if (sr == '0) begin
                bc_d = k + 1'b1;
              end
            end
          end else if (is_ct && k == CtFirst) begin
            cont_d = {1'b1, b};
            bc_d   = '0;
          end
          if (dr == '0) begin
            do_end = 1'b1;
          end
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end

    // Close the descriptor: a short event that did not finish cleanly
    // cancels the event's duration.
    if (do_end) begin
      if (is_se && bc_d != SeOk) begin
        dur_d = '0;
      end
      bc_d = '0;
      if (loop_d[LoopW-1] || loop_d == '0) begin
        do_fin = 1'b1;
      end else begin
        phase_d = PhDtag;
      end
    end

    if (do_fin) begin
      emit    = (dur_d != '0);
      do_next = 1'b1;
    end

    if (do_next) begin
      bc_d    = '0;
      phase_d = (rem_d >= EventHdrLen) ? PhEvent : PhIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      bc_q    <= '0;
      rem_q   <= '0;
      loop_q  <= '0;
      desc_q  <= '0;
      tag_q   <= '0;
      str_q   <= '0;
      svc_q   <= '0;
      ev_q    <= '0;
      start_q <= '0;
      dur_q   <= '0;
      cont_q  <= '0;
    end else begin
      phase_q <= phase_d;
      bc_q    <= bc_d;
      rem_q   <= rem_d;
      loop_q  <= loop_d;
      desc_q  <= desc_d;
      tag_q   <= tag_d;
      str_q   <= str_d;
      svc_q   <= svc_d;
      ev_q    <= ev_d;
      start_q <= start_d;
      dur_q   <= dur_d;
      cont_q  <= cont_d;
    end
  end

  assign emit_o                    = emit;
  assign result_o.service_ident    = svc_d;
  assign result_o.event_ident      = ev_d;
  assign result_o.start_raw        = start_d;
  assign result_o.duration_seconds = dur_d[DurW-1:0];
  assign result_o.content_byte     = cont_d[ByteW-1:0];
  assign result_o.content_present  = cont_d[ByteW];

endmodule

[sv/eitp_out_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EIT section parser output queue
// Two-entry result queue that decouples the parser from output stalls.
// ----------------------------------------------------------------------------
module eitp_out_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  eitp_pkg::result_t push_data_i,
  output logic              room_o,
  output logic              valid_o,
  input  logic              pop_ready_i,
  output eitp_pkg::result_t data_o
);
  import eitp_pkg::*;

  result_t     mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        pop;

  assign valid_o = (count_q != 2'd0);
  assign room_o  = (count_q != 2'd2);
  assign pop     = valid_o && pop_ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[sv/eit_section_event_parser_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EIT section event parser, top level
// Walks EIT section bodies bytewise; one request per nonzero-duration event.
// ----------------------------------------------------------------------------
// Throughput: one section byte per cycle; a two-entry output queue absorbs
// results, so the input stalls only while both entries hold untaken results.
// An event's result enters the output queue as its last byte is accepted and
// is offered on the output from the next cycle, behind any older results.
// Reset (rst_ni low, asynchronous) idles the parser, empties the queue and
// restores the tag registers to 77 and 84.
module eit_section_event_parser_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata, low to high: section_byte[7:0], table_ident[15:8],
  // body_length[27:16], zero padding[31:28].
  input  logic [eitp_pkg::InDataW-1:0]    s_axis_tdata,
  // tuser: section_start.
  input  logic                            s_axis_tuser,
  // Output stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata, low to high: service_ident[15:0], event_ident[31:16],
  // start_raw[71:32], duration_seconds[90:72], content_byte[98:91],
  // zero padding[103:99].
  output logic [eitp_pkg::OutDataW-1:0]   m_axis_tdata,
  // tuser: content_present.
  output logic                            m_axis_tuser,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [eitp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [eitp_pkg::ByteW-1:0]      cfg_data_i
);
  import eitp_pkg::*;

  cfg_t     cfg_q, cfg_d;
  in_item_t in_item;
  result_t  result, out_result;
  logic     in_accept, emit, room;

  // Configuration writes are always taken. Both tag registers are decoded
  // by index; the channel only ever carries valid indexes.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegShortEventTag: cfg_d.short_event_tag = cfg_data_i;
        RegContentTag:    cfg_d.content_tag     = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_event_tag <= ShortEventTagRst;
      cfg_q.content_tag     <= ContentTagRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // A byte is taken whenever the queue has a free entry, so the parser can
  // always store the result that the byte may produce.
  assign s_axis_tready = room;
  assign in_accept     = s_axis_tvalid && room;

  assign in_item.section_byte  = s_axis_tdata[7:0];
  assign in_item.table_ident   = s_axis_tdata[15:8];
  assign in_item.body_length   = s_axis_tdata[27:16];
  assign in_item.section_start = s_axis_tuser;

  eitp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_accept),
    .in_item_i  (in_item),
    .cfg_i      (cfg_q),
    .emit_o     (emit),
    .result_o   (result)
  );

  eitp_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (emit),
    .push_data_i (result),
    .room_o      (room),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (out_result)
  );

  // Pack the result fields, first field in the lowest bits.
  assign m_axis_tdata = {{(OutDataW - OutUsedW){1'b0}},
                         out_result.content_byte,
                         out_result.duration_seconds,
                         out_result.start_raw,
                         out_result.event_ident,
                         out_result.service_ident};
  assign m_axis_tuser = out_result.content_present;

endmodule

[sv/eitp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EIT section parser port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module eitp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Events with zero duration never produce a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[90:72] != 19'd0))
    else $error("result with zero duration");

  // Without a content descriptor the content byte is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[98:91] == 8'd0))
    else $error("content byte set without content descriptor");

  // Input back-pressure only happens while results are waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

endmodule

bind eit_section_event_parser_top eitp_checker u_eitp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[tb/eit_section_event_parser_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EIT section event parser testbench
// Feeds EIT section bodies byte by byte, mostly well-formed sections with
// random events and descriptors, plus rejected, short, truncated and stray
// input. Every output request is checked field by field against a byte-level
// parser model kept inside this bench or a hand-typed event, under several
// tag register settings and with random idling on both stream sides.
// ----------------------------------------------------------------------------
module eit_section_event_parser_top_tb;
  import eitp_pkg::*;

  // A directed row: one input request and, on rows whose result is obvious,
  // the event typed in by hand instead of the parser model's prediction.
  typedef struct packed {
    in_item_t item;
    bit       typed;
    result_t  want;
  } stim_row_t;

  // Tag register plan for the random chunks, chunk 0 in the lowest byte.
  // It covers the reset values, both extremes, equal tags and swapped tags.
  localparam logic [47:0] SeTagPlan = {8'd77, 8'd84, 8'h33, 8'hff, 8'h00, 8'd77};
  localparam logic [47:0] CtTagPlan = {8'd84, 8'd77, 8'h33, 8'h00, 8'hff, 8'd84};
  localparam int          ChunkItems = 250;
  localparam int          LongHold   = 300;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i;
  logic [ByteW-1:0]      cfg_data_i;

  // Events predicted but not yet seen on the output, oldest first.
  result_t   pending_events[$];
  stim_row_t opening_rows[$];
  in_item_t  section_items[$];

  int mismatch_count = 0;
  int send_gap_pct   = 0;
  int take_gap_pct   = 0;
  bit pressure_on    = 1'b0;
  bit receiver_blocked = 1'b0;

  // Parser model state. It mirrors the block's state after reset.
  phase_e       walk_ph     = PhIdle;
  int unsigned  step_pos    = 0;
  int           sect_left   = 0;
  int           loop_left   = 0;
  int unsigned  desc_left   = 0;
  logic [7:0]   desc_tag    = '0;
  int unsigned  text_left   = 0;
  logic [15:0]  cur_service = '0;
  logic [15:0]  cur_event   = '0;
  logic [39:0]  cur_start   = '0;
  int unsigned  cur_dur     = 0;
  logic [8:0]   cur_content = '0;
  logic [7:0]   se_tag      = ShortEventTagRst;
  logic [7:0]   ct_tag      = ContentTagRst;
  result_t      made;
  bit           made_valid;

  eit_section_event_parser_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------

  // Two BCD digits read as decimal; nibbles above nine are taken at face value.
  function automatic int unsigned bcd_pair(input logic [7:0] b);
    return b[7:4] * 10 + b[3:0];
  endfunction

  function automatic logic [7:0] to_bcd(input int unsigned v);
    return 8'(((v / 10) << 4) | (v % 10));
  endfunction

  // After an event, another header follows only if a whole one still fits.
  function automatic void seek_event_header();
    step_pos = 0;
    walk_ph  = (sect_left >= int'(EventHdrLen)) ? PhEvent : PhIdle;
  endfunction

  // An event with zero duration (never set, or cleared by a bad short event
  // descriptor) produces no request.
  function automatic void close_event();
    if (cur_dur > 0) begin
      made_valid             = 1'b1;
      made.service_ident     = cur_service;
      made.event_ident       = cur_event;
      made.start_raw         = cur_start;
      made.duration_seconds  = cur_dur[DurW-1:0];
      made.content_byte      = cur_content[7:0];
      made.content_present   = cur_content[8];
    end
    seek_event_header();
  endfunction

  function automatic void close_descriptor();
    if (desc_tag == se_tag && step_pos != SeOk) cur_dur = 0;
    step_pos = 0;
    if (loop_left <= 0) close_event();
    else walk_ph = PhDtag;
  endfunction

  // Advances the model by one accepted byte; made_valid tells whether the
  // byte completed an event, and made then holds it.
  function automatic void walk_section_byte(input in_item_t it);
    logic [7:0]  b;
    int unsigned k;
    made_valid = 1'b0;
    b = it.section_byte;
    if (it.section_start) begin
      step_pos = 0;
      if (it.table_ident < TidLow || it.table_ident > TidHigh ||
          it.body_length < MinBodyLen) begin
        walk_ph   = PhIdle;
        sect_left = 0;
        return;
      end
      walk_ph   = PhHeader;
      sect_left = int'(it.body_length);
    end
    if (walk_ph == PhIdle) return;
    if (sect_left <= 0) begin
      walk_ph = PhIdle;
      return;
    end
    sect_left--;
    k = step_pos;
    case (walk_ph)
      PhHeader: begin
        if (k == 0) cur_service = {b, 8'h00};
        else if (k == 1) cur_service[7:0] = b;
        step_pos = k + 1;
        if (step_pos >= HeaderBytes) seek_event_header();
      end
      PhEvent: begin
        if (k == 0) begin
          cur_event   = {b, 8'h00};
          cur_content = '0;
        end else if (k == 1) begin
          cur_event[7:0] = b;
        end else if (k == 2) begin
          cur_start = {32'h0, b};
        end else if (k <= 6) begin
          cur_start = {cur_start[31:0], b};
        end else if (k == 7) begin
          cur_dur = bcd_pair(b) * 3600;
        end else if (k == 8) begin
          cur_dur += bcd_pair(b) * 60;
        end else if (k == 9) begin
          cur_dur += bcd_pair(b);
          if (cur_dur > DurSatMax) cur_dur = 32'(DurSatMax);
        end else if (k == 10) begin
          loop_left = int'({b[3:0], 8'h00});
        end else begin
          loop_left = loop_left | int'(b);
          step_pos = 0;
          // A loop that overruns the section abandons the section at once.
          if (loop_left > sect_left) walk_ph = PhIdle;
          else if (loop_left == 0) close_event();
          else walk_ph = PhDtag;
          return;
        end
        step_pos = k + 1;
      end
      PhDtag: begin
        desc_tag = b;
        loop_left--;
        if (sect_left == 0) close_event();
        else walk_ph = PhDlen;
      end
      PhDlen: begin
        loop_left--;
        if (int'(b) > sect_left) begin
          close_event();
          return;
        end
        desc_left = 32'(b);
        step_pos  = 0;
        if (desc_tag != se_tag && desc_tag == ct_tag && b >= 2) step_pos = 32'(CtFirst);
        if (b == 0) close_descriptor();
        else walk_ph = PhDbody;
      end
      PhDbody: begin
        if (desc_left > 0) desc_left--;
        loop_left--;
        if (desc_tag == se_tag) begin
          // Language code, title length, title, text length, text.
          if (k < SeTlen) begin
            step_pos = k + 1;
          end else if (k == SeTlen || k == SeDlen) begin
            if (b > desc_left) begin
              step_pos = 32'(SeBad);
            end else begin
              text_left = 32'(b);
              if (k == SeTlen) step_pos = (b != 0) ? 32'(SeTitle) : 32'(SeDlen);
              else step_pos = (b != 0) ? 32'(SeDesc) : 32'(SeOk);
            end
          end else if (k == SeTitle || k == SeDesc) begin
            if (text_left > 0) text_left--;
            if (text_left == 0) step_pos = k + 1;
          end
        end else if (desc_tag == ct_tag && k == CtFirst) begin
          cur_content = {1'b1, b};
          step_pos    = 0;
        end
        if (desc_left == 0) close_descriptor();
      end
      default: walk_ph = PhIdle;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_row(input logic [7:0] b, input bit st,
                                  input logic [7:0] tid, input logic [11:0] len);
    stim_row_t r;
    r = '0;
    r.item.section_byte  = b;
    r.item.section_start = st;
    r.item.table_ident   = tid;
    r.item.body_length   = len;
    opening_rows.push_back(r);
  endfunction

  // Builds one section into section_items. Most sections are well formed
  // with random events and descriptors; a share are rejected, stray or cut.
  // useful counts the bytes that belong to a section the block must parse.
  task automatic compose_section(output int useful);
    logic [7:0]  body[$];
    logic [7:0]  loop_bytes[$];
    logic [7:0]  tid;
    logic [11:0] blen;
    logic [11:0] loop_len;
    logic [3:0]  spare;
    int unsigned sel, n_ev, n_desc, len, tl, dl, total, send_n, i;
    bit          start_flag;
    in_item_t    it;
    body = {};
    section_items = {};
    tid = 8'($urandom_range(TidHigh, TidLow));
    repeat (11) body.push_back(8'($urandom_range(255)));
    n_ev = $urandom_range(4, 1);
    repeat (n_ev) begin
      loop_bytes = {};
      n_desc = $urandom_range(3);
      repeat (n_desc) begin
        case ($urandom_range(4))
          0, 1: begin
            tl = $urandom_range(3);
            dl = $urandom_range(3);
            loop_bytes.push_back(se_tag);
            loop_bytes.push_back(8'(5 + tl + dl));
            repeat (3) loop_bytes.push_back(8'($urandom_range(255)));
            loop_bytes.push_back(8'(tl));
            repeat (tl) loop_bytes.push_back(8'($urandom_range(255)));
            loop_bytes.push_back(8'(dl));
            repeat (dl) loop_bytes.push_back(8'($urandom_range(255)));
          end
          2: begin
            // Broken short event: too short, text length missing, title
            // length too large, or text length too large.
            tl = $urandom_range(2);
            dl = $urandom_range(3, 1);
            loop_bytes.push_back(se_tag);
            case ($urandom_range(3))
              0: begin
                len = $urandom_range(3);
                loop_bytes.push_back(8'(len));
                repeat (len) loop_bytes.push_back(8'($urandom_range(255)));
              end
              1: begin
                loop_bytes.push_back(8'(4 + tl));
                repeat (3) loop_bytes.push_back(8'($urandom_range(255)));
                loop_bytes.push_back(8'(tl));
                repeat (tl) loop_bytes.push_back(8'($urandom_range(255)));
              end
              2: begin
                loop_bytes.push_back(8'(5 + tl + dl));
                repeat (3) loop_bytes.push_back(8'($urandom_range(255)));
                loop_bytes.push_back(8'(tl + dl + 2));
                repeat (tl + 1 + dl) loop_bytes.push_back(8'($urandom_range(255)));
              end
              default: begin
                loop_bytes.push_back(8'(5 + tl + dl));
                repeat (3) loop_bytes.push_back(8'($urandom_range(255)));
                loop_bytes.push_back(8'(tl));
                repeat (tl) loop_bytes.push_back(8'($urandom_range(255)));
                loop_bytes.push_back(8'(dl + 1));
                repeat (dl) loop_bytes.push_back(8'($urandom_range(255)));
              end
            endcase
          end
          3: begin
            len = $urandom_range(4);
            loop_bytes.push_back(ct_tag);
            loop_bytes.push_back(8'(len));
            repeat (len) loop_bytes.push_back(8'($urandom_range(255)));
          end
          default: begin
            len = $urandom_range(5);
            loop_bytes.push_back(8'($urandom_range(255)));
            loop_bytes.push_back(8'(len));
            repeat (len) loop_bytes.push_back(8'($urandom_range(255)));
          end
        endcase
      end
      // Event id and start time, then the duration.
      repeat (7) body.push_back(8'($urandom_range(255)));
      case ($urandom_range(9))
        0: repeat (3) body.push_back(8'h00);
        1: repeat (3) body.push_back(8'($urandom_range(255)));
        default: begin
          body.push_back(to_bcd($urandom_range(99)));
          body.push_back(to_bcd($urandom_range(59)));
          body.push_back(to_bcd($urandom_range(59)));
        end
      endcase
      // Mostly the true loop length; sometimes a wild one or a short one
      // that leaves a descriptor running past the end of its loop.
      loop_len = 12'(loop_bytes.size());
      if ($urandom_range(15) == 0) loop_len = 12'($urandom_range(4095));
      else if ($urandom_range(7) == 0 && loop_len > 0)
        loop_len = 12'($urandom_range(loop_len - 1));
      spare = 4'($urandom_range(15));
      body.push_back({spare, loop_len[11:8]});
      body.push_back(loop_len[7:0]);
      foreach (loop_bytes[j]) body.push_back(loop_bytes[j]);
    end
    // Occasionally a tail too short for another event header.
    if ($urandom_range(7) == 0)
      repeat ($urandom_range(11, 1)) body.push_back(8'($urandom_range(255)));
    total = body.size();
    case ($urandom_range(19))
      0: blen = 12'($urandom_range(total, 11));
      1: blen = 12'($urandom_range(4092, total));
      2: blen = 12'd4092;
      default: blen = 12'(total);
    endcase
    send_n = total;
    start_flag = 1'b1;
    sel = $urandom_range(99);
    if (sel < 4) begin
      tid = 8'($urandom_range(255));
      if (tid >= TidLow && tid <= TidHigh) tid = tid ^ 8'h80;
    end else if (sel < 7) begin
      blen = 12'($urandom_range(10));
    end else if (sel < 10) begin
      start_flag = 1'b0;
    end else if (sel < 14) begin
      send_n = $urandom_range(total, 1);
    end
    for (i = 0; i < send_n; i++) begin
      it.section_byte  = body[i];
      it.section_start = (i == 0) && start_flag;
      it.table_ident   = it.section_start ? tid : 8'($urandom_range(255));
      it.body_length   = it.section_start ? blen : 12'($urandom_range(4092));
      section_items.push_back(it);
    end
    useful = (sel >= 10) ? int'(send_n) : 0;
  endtask

  // Offers one input request, with random idle cycles in front of it, and
  // feeds it to the parser model once the block takes it.
  task automatic send_item(input in_item_t it, input bit typed, input result_t typed_want);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, it.body_length, it.table_ident, it.section_byte};
    s_axis_tuser  <= it.section_start;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    walk_section_byte(it);
    if (typed) pending_events.push_back(typed_want);
    else if (made_valid) pending_events.push_back(made);
  endtask

  // Writes both tag registers; only called while the block is idle.
  task automatic set_tags(input logic [7:0] se, input logic [7:0] ct);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= RegShortEventTag;
    cfg_data_i  <= se;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    se_tag = se;
    cfg_index_i <= RegContentTag;
    cfg_data_i  <= ct;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    ct_tag = ct;
    cfg_valid_i <= 1'b0;
  endtask

  // Waits for every predicted event, then a few more cycles so that a byte
  // that produced nothing has surely left the pipeline.
  task automatic settle(input int extra);
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // Compares one output request with the oldest predicted event.
  task automatic take_result();
    result_t want;
    if (pending_events.size() == 0) begin
      flag_mismatch($sformatf("unexpected event %h", m_axis_tdata));
      return;
    end
    want = pending_events.pop_front();
    if (m_axis_tdata[15:0] !== want.service_ident)
      flag_mismatch($sformatf("service_ident %h, expected %h",
                              m_axis_tdata[15:0], want.service_ident));
    if (m_axis_tdata[31:16] !== want.event_ident)
      flag_mismatch($sformatf("event_ident %h, expected %h",
                              m_axis_tdata[31:16], want.event_ident));
    if (m_axis_tdata[71:32] !== want.start_raw)
      flag_mismatch($sformatf("start_raw %h, expected %h",
                              m_axis_tdata[71:32], want.start_raw));
    if (m_axis_tdata[90:72] !== want.duration_seconds)
      flag_mismatch($sformatf("duration_seconds %0d, expected %0d",
                              m_axis_tdata[90:72], want.duration_seconds));
    if (m_axis_tdata[98:91] !== want.content_byte)
      flag_mismatch($sformatf("content_byte %h, expected %h",
                              m_axis_tdata[98:91], want.content_byte));
    if (m_axis_tuser !== want.content_present)
      flag_mismatch($sformatf("content_present %b, expected %b",
                              m_axis_tuser, want.content_present));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: samples the output handshake at each rising edge and decides
  // the next ready value, either at random or held low during a long hold.
  // ---------------------------------------------------------------------------
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) take_result();
      if (receiver_blocked) m_axis_tready <= 1'b0;
      else m_axis_tready <= ($urandom_range(99) >= take_gap_pct);
    end
  end

  // Long receiver hold: once the pressure chunk begins, the output is refused
  // for a fixed stretch while the sender keeps offering bytes, so the output
  // queue fills and the block has to push back on its input.
  initial begin
    while (!pressure_on) @(posedge clk_i);
    receiver_blocked <= 1'b1;
    repeat (LongHold) @(posedge clk_i);
    receiver_blocked <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t last_row;
    int        useful;
    int        sent_useful;
    int        chunk;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = RegShortEventTag;
    cfg_data_i    = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_tags(ShortEventTagRst, ContentTagRst);

    // Directed part: a stray byte while idle, a table id just below the
    // accepted range with the largest length, a body one byte too short,
    // then a minimal section at the top of the id range whose single event
    // carries all-ones fields, so the duration saturates.
    add_row(8'ha5, 1'b0, 8'h00, 12'd0);
    add_row(8'h00, 1'b1, 8'h4d, 12'd4092);
    add_row(8'h11, 1'b0, 8'h00, 12'd0);
    add_row(8'h00, 1'b1, 8'h4e, 12'd10);
    add_row(8'h00, 1'b1, 8'h6f, 12'd23);
    add_row(8'h00, 1'b0, 8'h00, 12'd0);
    repeat (9) add_row(8'hff, 1'b0, 8'h00, 12'd0);
    repeat (10) add_row(8'hff, 1'b0, 8'h00, 12'd0);
    // Loop length high byte: only the low nibble counts, so the loop is empty.
    add_row(8'hf0, 1'b0, 8'h00, 12'd0);
    last_row = '0;
    last_row.typed                 = 1'b1;
    last_row.want.service_ident    = 16'h0000;
    last_row.want.event_ident      = 16'hffff;
    last_row.want.start_raw        = 40'hff_ffff_ffff;
    last_row.want.duration_seconds = 19'h7ffff;
    last_row.want.content_byte     = 8'h00;
    last_row.want.content_present  = 1'b0;
    opening_rows.push_back(last_row);

    send_gap_pct = 38;
    take_gap_pct <= 49;
    foreach (opening_rows[i]) send_item(opening_rows[i].item, opening_rows[i].typed,
                                        opening_rows[i].want);
    s_axis_tvalid <= 1'b0;
    settle(4);

    // Random part in six chunks: the receiver idles more in the first pair,
    // the sender in the second, and neither in the last, which also holds
    // the long receiver stall.
    for (chunk = 0; chunk < 6; chunk++) begin
      set_tags(SeTagPlan[8*chunk +: 8], CtTagPlan[8*chunk +: 8]);
      case (chunk / 2)
        0: begin
          send_gap_pct = 38;
          take_gap_pct <= 49;
        end
        1: begin
          send_gap_pct = 49;
          take_gap_pct <= 38;
        end
        default: begin
          send_gap_pct = 0;
          take_gap_pct <= 0;
        end
      endcase
      if (chunk == 4) pressure_on <= 1'b1;
      sent_useful = 0;
      while (sent_useful < ChunkItems) begin
        compose_section(useful);
        foreach (section_items[j]) send_item(section_items[j], 1'b0, '0);
        sent_useful += useful;
      end
      s_axis_tvalid <= 1'b0;
      settle(4);
    end

    settle(20);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Safety net: far beyond the slowest correct run, including the long hold.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

[eit_section_event_parser_top.f]
sv/eitp_pkg.sv
sv/eitp_parser.sv
sv/eitp_out_queue.sv
sv/eit_section_event_parser_top.sv
sv/eitp_checker.sv
tb/eit_section_event_parser_top_tb.sv
